// ----- hdl/wctrim_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wctrim_pkg
// Shared types, heading codes and duty trim helpers for the wall-centering
// duty trim block.
// ----------------------------------------------------------------------------
package wctrim_pkg;

  localparam int DUTY_W             = 8;
  localparam int HEADING_W          = 3;
  localparam int DUTY_MAX_DEF       = 255;
  localparam int DISTANCE_WIDTH_DEF = 10;

  // heading codes, anything above HDG_270 means no correction
  localparam logic [HEADING_W-1:0] HDG_360 = 3'd0;
  localparam logic [HEADING_W-1:0] HDG_90  = 3'd1;
  localparam logic [HEADING_W-1:0] HDG_180 = 3'd2;
  localparam logic [HEADING_W-1:0] HDG_270 = 3'd3;

  typedef enum logic [1:0] {
    SEL_AC,
    SEL_BD,
    SEL_A,
    SEL_C
  } trim_sel_t;

  typedef struct packed {
    logic [DUTY_W-1:0] a;
    logic [DUTY_W-1:0] c;
    logic [DUTY_W-1:0] bd;
  } levels_t;

  function automatic logic [DUTY_W-1:0] lvl_inc(logic [DUTY_W-1:0] v,
                                                logic [DUTY_W-1:0] dmax);
    return (v >= dmax) ? v : v + 1'b1;
  endfunction

  function automatic logic [DUTY_W-1:0] lvl_dec(logic [DUTY_W-1:0] v);
    return (v == '0) ? v : v - 1'b1;
  endfunction

  function automatic levels_t trim_apply(levels_t l, trim_sel_t sel,
                                         logic [DUTY_W-1:0] dmax);
    levels_t r;
    r = l;
    case (sel)
      SEL_AC: begin
        if (l.a >= dmax || l.c >= dmax) begin
          r.bd = lvl_dec(l.bd);
        end else begin
          r.a = lvl_inc(l.a, dmax);
          r.c = lvl_inc(l.c, dmax);
        end
      end
      SEL_BD: begin
        if (l.bd >= dmax) begin
          r.a = lvl_dec(l.a);
          r.c = lvl_dec(l.c);
        end else begin
          r.bd = lvl_inc(l.bd, dmax);
        end
      end
      SEL_A: begin
        if (l.a < dmax) r.a = lvl_inc(l.a, dmax);
        else            r.c = lvl_dec(l.c);
      end
      default: begin
        if (l.c < dmax) r.c = lvl_inc(l.c, dmax);
        else            r.a = lvl_dec(l.a);
      end
    endcase
    return r;
  endfunction

endpackage

// ----- hdl/wctrim_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wctrim_step
// One trim pass: centering on an opposite side pair, then twist correction
// on a corner pair, applied to the current duty levels.
// ----------------------------------------------------------------------------
module wctrim_step
  import wctrim_pkg::*;
#(
  parameter int DUTY_MAX       = DUTY_MAX_DEF,
  parameter int DISTANCE_WIDTH = DISTANCE_WIDTH_DEF
) (
  input  levels_t                   lvl_cur,
  input  logic [DISTANCE_WIDTH-1:0] dist_front,
  input  logic [DISTANCE_WIDTH-1:0] dist_right,
  input  logic [DISTANCE_WIDTH-1:0] dist_back,
  input  logic [DISTANCE_WIDTH-1:0] dist_left,
  input  logic [DISTANCE_WIDTH-1:0] dist_front_right,
  input  logic [DISTANCE_WIDTH-1:0] dist_back_right,
  input  logic [DISTANCE_WIDTH-1:0] dist_back_left,
  input  logic [DISTANCE_WIDTH-1:0] dist_front_left,
  input  logic [HEADING_W-1:0]      heading,
  output levels_t                   lvl_nxt
);

  localparam logic [DUTY_W-1:0] DMAX = DUTY_W'(DUTY_MAX);

  logic [DISTANCE_WIDTH-1:0] cen_x, cen_y, tw_x, tw_y;
  trim_sel_t                 cen_gt, cen_lt, tw_gt, tw_lt;
  logic                      hdg_ok;
  levels_t                   lvl_mid;

  always_comb begin
    hdg_ok = 1'b1;
    cen_x  = dist_left;
    cen_y  = dist_right;
    cen_gt = SEL_AC;
    cen_lt = SEL_BD;
    tw_x   = dist_front_right;
    tw_y   = dist_back_right;
    tw_gt  = SEL_C;
    tw_lt  = SEL_A;
    case (heading)
      HDG_360: begin
      end
      HDG_90: begin
        cen_x  = dist_front;
        cen_y  = dist_back;
        cen_gt = SEL_BD;
        cen_lt = SEL_AC;
        tw_y   = dist_front_left;
      end
      HDG_180: begin
        cen_gt = SEL_BD;
        cen_lt = SEL_AC;
        tw_x   = dist_back_left;
        tw_y   = dist_front_left;
        tw_gt  = SEL_A;
        tw_lt  = SEL_C;
      end
      HDG_270: begin
        cen_x = dist_front;
        cen_y = dist_back;
        tw_x  = dist_back_right;
        tw_y  = dist_back_left;
      end
      default: hdg_ok = 1'b0;
    endcase
  end

  always_comb begin
    lvl_mid = lvl_cur;
    if (hdg_ok && cen_x != cen_y) begin
      lvl_mid = trim_apply(lvl_cur, (cen_x > cen_y) ? cen_gt : cen_lt, DMAX);
    end
    lvl_nxt = lvl_mid;
    if (hdg_ok && tw_x != tw_y) begin
      lvl_nxt = trim_apply(lvl_mid, (tw_x > tw_y) ? tw_gt : tw_lt, DMAX);
    end
  end

endmodule

// ----- hdl/wall_centering_duty_trim.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wall_centering_duty_trim
// Path: an input transaction passes through the input register and then the
// duty level register before its result transaction appears.
// Throughput: one transaction per cycle while out_stall is low; the duty level register is the
// result register, updated as a frame moves out of the input register.
// Reset: synchronous active-low rst_n clears both valid flags and sets all
// three duty levels to zero.
// ----------------------------------------------------------------------------
module wall_centering_duty_trim
  import wctrim_pkg::*;
#(
  parameter int DUTY_MAX       = DUTY_MAX_DEF,
  parameter int DISTANCE_WIDTH = DISTANCE_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [DISTANCE_WIDTH-1:0] in_dist_front,
  input  logic [DISTANCE_WIDTH-1:0] in_dist_right,
  input  logic [DISTANCE_WIDTH-1:0] in_dist_back,
  input  logic [DISTANCE_WIDTH-1:0] in_dist_left,
  input  logic [DISTANCE_WIDTH-1:0] in_dist_front_right,
  input  logic [DISTANCE_WIDTH-1:0] in_dist_back_right,
  input  logic [DISTANCE_WIDTH-1:0] in_dist_back_left,
  input  logic [DISTANCE_WIDTH-1:0] in_dist_front_left,
  input  logic [HEADING_W-1:0]      in_heading,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [DUTY_W-1:0]         out_duty_a,
  output logic [DUTY_W-1:0]         out_duty_c,
  output logic [DUTY_W-1:0]         out_duty_bd
);

  logic                      s1_valid_r, s1_valid_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [DISTANCE_WIDTH-1:0] front_r, right_r, back_r, left_r;
  logic [DISTANCE_WIDTH-1:0] front_right_r, back_right_r, back_left_r, front_left_r;
  logic [HEADING_W-1:0]      heading_r;
  levels_t                   lvl_r, lvl_nxt, lvl_step;
  logic                      advance, in_take;

  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  wctrim_step #(
    .DUTY_MAX       (DUTY_MAX),
    .DISTANCE_WIDTH (DISTANCE_WIDTH)
  ) u_step (
    .lvl_cur          (lvl_r),
    .dist_front       (front_r),
    .dist_right       (right_r),
    .dist_back        (back_r),
    .dist_left        (left_r),
    .dist_front_right (front_right_r),
    .dist_back_right  (back_right_r),
    .dist_back_left   (back_left_r),
    .dist_front_left  (front_left_r),
    .heading          (heading_r),
    .lvl_nxt          (lvl_step)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take)      s1_valid_nxt = 1'b1;
    else if (advance) s1_valid_nxt = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    if (advance) out_valid_nxt = 1'b1;
    lvl_nxt = advance ? lvl_step : lvl_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      lvl_r       <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      lvl_r       <= lvl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      front_r       <= in_dist_front;
      right_r       <= in_dist_right;
      back_r        <= in_dist_back;
      left_r        <= in_dist_left;
      front_right_r <= in_dist_front_right;
      back_right_r  <= in_dist_back_right;
      back_left_r   <= in_dist_back_left;
      front_left_r  <= in_dist_front_left;
      heading_r     <= in_heading;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_duty_a  = lvl_r.a;
  assign out_duty_c  = lvl_r.c;
  assign out_duty_bd = lvl_r.bd;

endmodule

// ----- hdl/wctrim_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wctrim_checker
// Port-level checks for the wall-centering duty trim block, bound to the
// top level.
// ----------------------------------------------------------------------------
module wctrim_checker
  import wctrim_pkg::*;
#(
  parameter int DUTY_MAX = DUTY_MAX_DEF
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [DUTY_W-1:0] out_duty_a,
  input logic [DUTY_W-1:0] out_duty_c,
  input logic [DUTY_W-1:0] out_duty_bd
);

  localparam logic [DUTY_W-1:0] DMAX = DUTY_W'(DUTY_MAX);

  // stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_duty_a)
      && $stable(out_duty_c) && $stable(out_duty_bd))
    else $error("stalled result changed");

  // every accepted input transaction is followed by out_valid high
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> ##2 out_valid)
    else $error("input transaction produced no result");

  // with the result side empty the input is never held off
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while result register empty");

  // duty levels never pass the ceiling
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_duty_a <= DMAX && out_duty_c <= DMAX && out_duty_bd <= DMAX)
    else $error("duty level above ceiling");

  // nothing valid right after reset
  assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind wall_centering_duty_trim wctrim_checker #(
  .DUTY_MAX (DUTY_MAX)
) u_wctrim_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_duty_a  (out_duty_a),
  .out_duty_c  (out_duty_c),
  .out_duty_bd (out_duty_bd)
);
